// File: sv/arvc_pkg.sv
package arvc_pkg;

  localparam logic [15:0] CLUSTER_FLOW = 16'h0404;
  localparam logic [15:0] CLUSTER_BATT = 16'h0001;
  localparam logic [7:0]  CMD_REPORT   = 8'h0A;
  localparam logic [15:0] ATTR_FLOW    = 16'h0000;
  localparam logic [15:0] ATTR_BATT    = 16'h0021;
  localparam logic [7:0]  TYPE_FLOW    = 8'h21;
  localparam logic [7:0]  TYPE_BATT    = 8'h20;
  localparam logic [15:0] FLOW_ZERO    = 16'h0000;
  localparam logic [15:0] THRESHOLD_RESET = 16'd60;

  localparam logic [2:0] POS_ID_LOW  = 3'd0;
  localparam logic [2:0] POS_ID_HIGH = 3'd1;
  localparam logic [2:0] POS_TYPE    = 3'd2;
  localparam logic [2:0] POS_VAL_LOW = 3'd3;
  localparam logic [2:0] POS_VAL_HIGH = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FLOW = 2'd1;
  localparam logic [1:0] KIND_BATT = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_OPEN  = 2'd2;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] cluster_code;
    logic [7:0]  command_code;
    logic        last_byte;
  } report_in_t;

  typedef struct packed {
    logic [15:0] flow_now;
    logic [6:0]  battery_now;
    logic        valve_state;
    logic [1:0]  valve_action;
    logic        data_changed;
  } report_out_t;

endpackage

// File: sv/attribute_report_valve_control.sv
// Parses attribute-report payload bytes, one item per byte, and keeps the latest flow and
// battery readings. One item is accepted every cycle unless a held last byte waits on a full
// result register; an item passes an input register and then that result register, which is
// loaded when the held last byte of a report frame advances. Bytes of frames that are not
// reports are dropped without effect. On the last byte of a report frame one result is given;
// when a reading changed in that frame, flow above close_threshold closes an open valve and
// zero flow opens a closed one. The threshold resets to 60 and is written through cfg_wr_en
// and cfg_wr_data, by the user only while the block is idle; the block does not enforce this.
module attribute_report_valve_control (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  arvc_pkg::report_in_t      in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output arvc_pkg::report_out_t     out_item,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data
);

  logic                 held_valid;
  arvc_pkg::report_in_t held_item;
  logic [15:0]          close_threshold;

  logic [2:0]  record_position, record_position_next;
  logic [15:0] attribute_id, attribute_id_next;
  logic [7:0]  value_low_byte, value_low_byte_next;
  logic [1:0]  record_kind, record_kind_next;
  logic        parse_stopped, parse_stopped_next;
  logic        frame_updated, frame_updated_next;
  logic [15:0] flow_value, flow_value_next;
  logic [6:0]  battery_level, battery_level_next;
  logic        valve_is_open, valve_is_open_next;

  logic                  is_report;
  logic                  produce;
  logic                  advance;
  logic [15:0]           record_value;
  logic [1:0]            action;
  arvc_pkg::report_out_t result;

  assign is_report = held_item.command_code == arvc_pkg::CMD_REPORT;
  assign produce   = is_report && held_item.last_byte;
  assign advance   = held_valid && (!produce || !out_valid || out_ready);
  assign in_ready  = !held_valid || advance;
  assign record_value = {held_item.payload_byte, value_low_byte};

  always_comb begin
    record_position_next = record_position;
    attribute_id_next    = attribute_id;
    value_low_byte_next  = value_low_byte;
    record_kind_next     = record_kind;
    parse_stopped_next   = parse_stopped;
    frame_updated_next   = frame_updated;
    flow_value_next      = flow_value;
    battery_level_next   = battery_level;
    valve_is_open_next   = valve_is_open;
    action               = arvc_pkg::ACT_NONE;

    if (!parse_stopped) begin
      case (record_position)
        arvc_pkg::POS_ID_HIGH: begin
          attribute_id_next    = {held_item.payload_byte, attribute_id[7:0]};
          record_position_next = arvc_pkg::POS_TYPE;
        end
        arvc_pkg::POS_TYPE: begin
          if (held_item.cluster_code == arvc_pkg::CLUSTER_FLOW &&
              attribute_id == arvc_pkg::ATTR_FLOW &&
              held_item.payload_byte == arvc_pkg::TYPE_FLOW) begin
            record_kind_next     = arvc_pkg::KIND_FLOW;
            record_position_next = arvc_pkg::POS_VAL_LOW;
          end else if (held_item.cluster_code == arvc_pkg::CLUSTER_BATT &&
                       attribute_id == arvc_pkg::ATTR_BATT &&
                       held_item.payload_byte == arvc_pkg::TYPE_BATT) begin
            record_kind_next     = arvc_pkg::KIND_BATT;
            record_position_next = arvc_pkg::POS_VAL_LOW;
          end else begin
            record_kind_next   = arvc_pkg::KIND_NONE;
            parse_stopped_next = 1'b1;
          end
        end
        arvc_pkg::POS_VAL_LOW: begin
          if (record_kind == arvc_pkg::KIND_FLOW) begin
            value_low_byte_next  = held_item.payload_byte;
            record_position_next = arvc_pkg::POS_VAL_HIGH;
          end else begin
            if (held_item.payload_byte[7:1] != battery_level) begin
              battery_level_next = held_item.payload_byte[7:1];
              frame_updated_next = 1'b1;
            end
            record_kind_next     = arvc_pkg::KIND_NONE;
            record_position_next = arvc_pkg::POS_ID_LOW;
          end
        end
        arvc_pkg::POS_VAL_HIGH: begin
          if (record_value != flow_value) begin
            flow_value_next    = record_value;
            frame_updated_next = 1'b1;
          end
          record_kind_next     = arvc_pkg::KIND_NONE;
          record_position_next = arvc_pkg::POS_ID_LOW;
        end
        default: begin
          attribute_id_next    = {8'h00, held_item.payload_byte};
          record_position_next = arvc_pkg::POS_ID_HIGH;
        end
      endcase
    end

    if (held_item.last_byte && frame_updated_next) begin
      if (flow_value_next > close_threshold) begin
        if (valve_is_open) begin
          valve_is_open_next = 1'b0;
          action             = arvc_pkg::ACT_CLOSE;
        end
      end else if (flow_value_next == arvc_pkg::FLOW_ZERO) begin
        if (!valve_is_open) begin
          valve_is_open_next = 1'b1;
          action             = arvc_pkg::ACT_OPEN;
        end
      end
    end

    result.flow_now     = flow_value_next;
    result.battery_now  = battery_level_next;
    result.valve_state  = valve_is_open_next;
    result.valve_action = action;
    result.data_changed = frame_updated_next;

    if (held_item.last_byte) begin
      record_position_next = arvc_pkg::POS_ID_LOW;
      attribute_id_next    = 16'h0000;
      value_low_byte_next  = 8'h00;
      record_kind_next     = arvc_pkg::KIND_NONE;
      parse_stopped_next   = 1'b0;
      frame_updated_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      close_threshold <= arvc_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      close_threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_position <= arvc_pkg::POS_ID_LOW;
      attribute_id    <= 16'h0000;
      value_low_byte  <= 8'h00;
      record_kind     <= arvc_pkg::KIND_NONE;
      parse_stopped   <= 1'b0;
      frame_updated   <= 1'b0;
      flow_value      <= 16'h0000;
      battery_level   <= 7'd0;
      valve_is_open   <= 1'b1;
    end else if (advance && is_report) begin
      record_position <= record_position_next;
      attribute_id    <= attribute_id_next;
      value_low_byte  <= value_low_byte_next;
      record_kind     <= record_kind_next;
      parse_stopped   <= parse_stopped_next;
      frame_updated   <= frame_updated_next;
      flow_value      <= flow_value_next;
      battery_level   <= battery_level_next;
      valve_is_open   <= valve_is_open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      out_item <= result;
    end
  end

  a_action_needs_change: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.valve_action != arvc_pkg::ACT_NONE |-> out_item.data_changed)
    else $error("valve action without changed data");

  a_close_leaves_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.valve_action == arvc_pkg::ACT_CLOSE |-> !out_item.valve_state)
    else $error("close action with valve open");

  a_open_needs_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.valve_action == arvc_pkg::ACT_OPEN
      |-> out_item.valve_state && out_item.flow_now == arvc_pkg::FLOW_ZERO)
    else $error("open action without zero flow");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    record_position <= arvc_pkg::POS_VAL_HIGH)
    else $error("record position out of range");

  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && produce |=> record_position == arvc_pkg::POS_ID_LOW && !parse_stopped
      && !frame_updated && out_valid)
    else $error("frame state not cleared after last byte");

endmodule
